@@ hw/rtl/drct_pkg.sv @@
// shared widths and register codes for the dram conflict timing block
package drct_pkg;

  // request and response field widths
  localparam int TS_W       = 48;
  localparam int ADDR_W     = 48;
  localparam int LAT_W      = 32;
  localparam int TOTAL_W    = 64;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // configuration register widths
  localparam int CMD_MULT_W  = 8;
  localparam int BANK_MULT_W = 8;
  localparam int TRC_W       = 12;
  localparam int TRAS_W      = 12;
  localparam int XFER_W      = 12;
  localparam int SHIFT_W     = 4;

  // remainder unit consumes this many timestamp bits per cycle
  localparam int DIGIT_W     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CMD_CLOCK_MULT  = 3'd0,
    REG_BANK_CLOCK_MULT = 3'd1,
    REG_ROW_CYCLE_TIME  = 3'd2,
    REG_ROW_ACTIVE_TIME = 3'd3,
    REG_TRANSFER_TIME   = 3'd4,
    REG_LINE_SIZE_LOG   = 3'd5
  } cfg_reg_t;

endpackage

@@ hw/rtl/drct_intf.sv @@
// request, response and configuration channel interfaces
interface drct_req_if;
  import drct_pkg::*;
  logic              valid;
  logic              ready;
  logic [TS_W-1:0]   timestamp;
  logic [ADDR_W-1:0] phys_address;

  modport source (output valid, timestamp, phys_address, input ready);
  modport sink   (input valid, timestamp, phys_address, output ready);
endinterface

interface drct_rsp_if;
  import drct_pkg::*;
  logic               valid;
  logic               ready;
  logic [LAT_W-1:0]   access_latency;
  logic [TOTAL_W-1:0] latency_total;

  modport source (output valid, access_latency, latency_total, input ready);
  modport sink   (input valid, access_latency, latency_total, output ready);
endinterface

interface drct_cfg_if;
  import drct_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/drct_tables.sv @@
// last-access-time memory holding all four resource levels, with clearing pass
module drct_tables #(
  parameter int DEPTH  = 90,
  parameter int DATA_W = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  output logic                     clear_done,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);
  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     clr_addr;
  logic              clearing;

  logic              we;
  logic [AW-1:0]     wa;
  logic [DATA_W-1:0] wd;

  always_comb begin
    we = clearing | wr_en;
    wa = clearing ? clr_addr : wr_addr;
    wd = clearing ? '0 : wr_data;
  end

  // sweep every entry once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign clear_done = ~clearing;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/drct_rem.sv @@
// iterative remainder of a time value by the 8-bit command multiplier
module drct_rem #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [TIME_WIDTH-1:0] value,
  input  logic [7:0]            divisor,
  output logic                  done,
  output logic [7:0]            remainder
);
  import drct_pkg::*;

  localparam int NDIG = (TIME_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int TP   = NDIG * DIGIT_W;
  localparam int DCW  = $clog2(NDIG + 1);

  logic [TP-1:0]  sh;
  logic [DCW-1:0] cnt;
  logic           busy;
  logic [7:0]     rem_step;

  // restoring step, DIGIT_W bits per cycle, msb first
  always_comb begin
    logic [8:0] x;
    logic [7:0] r;
    r = remainder;
    for (int k = 0; k < DIGIT_W; k++) begin
      x = {r, sh[TP-1-k]};
      if (x >= {1'b0, divisor}) begin
        x = x - {1'b0, divisor};
      end
      r = x[7:0];
    end
    rem_step = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        sh        <= TP'(value);
        cnt       <= '0;
        remainder <= '0;
      end else if (busy) begin
        remainder <= rem_step;
        sh        <= sh << DIGIT_W;
        cnt       <= cnt + DCW'(1);
        if (cnt == DCW'(NDIG - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/drct_alu.sv @@
// shared saturating time adder with max against a floor time
module drct_alu #(
  parameter int TIME_WIDTH = 48
) (
  input  logic [TIME_WIDTH-1:0] a,
  input  logic [TIME_WIDTH-1:0] b,
  input  logic [TIME_WIDTH-1:0] floor_time,
  output logic [TIME_WIDTH-1:0] y
);
  localparam logic [TIME_WIDTH:0] TMAX = {1'b0, {TIME_WIDTH{1'b1}}};

  logic [TIME_WIDTH:0]   sum;
  logic [TIME_WIDTH-1:0] sat;

  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    sat = (sum >= TMAX) ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
    y   = (sat > floor_time) ? sat : floor_time;
  end

endmodule

@@ hw/rtl/dram_resource_conflict_timing.sv @@
// dram resource-conflict timing: sequencer, configuration registers and output
//
//  channel  dir  payload                          handshake
//  req      in   timestamp, phys_address          valid / ready
//  rsp      out  access_latency, latency_total    valid / ready
//  cfg      in   index, data                      valid / ready (always ready)
//
//  a request runs from acceptance through the remainder unit, which walks the
//  timestamp four bits a cycle and then hands over; then one shared adder
//  serves alignment and the four levels, each level a read and a write on the
//  single last-time memory, and the latency, saturation and sum states finish
//  it before the response is offered.
//  after reset a clearing pass over CHANNELS + device + dimm + bank entries
//  (78 entries at the defaults) runs before req.ready rises.
//  req.ready is low from acceptance until the response has been taken.
module dram_resource_conflict_timing #(
  parameter int CHANNELS          = 2,
  parameter int DEVICES_PER_DIMM  = 2,
  parameter int DIMMS_PER_CHANNEL = 2,
  parameter int BANKS_PER_DEVICE  = 8,
  parameter int TIME_WIDTH        = 48
) (
  input  logic               clk,
  input  logic               rst,
  drct_req_if.sink           req,
  drct_rsp_if.source         rsp,
  drct_cfg_if.sink           cfg
);
  import drct_pkg::*;

  // table geometry; all counts must be powers of two, which the block itself does not enforce
  localparam int DEV_COUNT  = CHANNELS * DEVICES_PER_DIMM;
  localparam int DIMM_COUNT = DEV_COUNT * DIMMS_PER_CHANNEL;
  localparam int BANK_COUNT = DIMM_COUNT * BANKS_PER_DEVICE;
  localparam int DEPTH      = CHANNELS + DEV_COUNT + DIMM_COUNT + BANK_COUNT;
  localparam int AW         = $clog2(DEPTH);
  localparam int LW         = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

  localparam int BASE_DEV   = CHANNELS;
  localparam int BASE_DIMM  = CHANNELS + DEV_COUNT;
  localparam int BASE_BANK  = CHANNELS + DEV_COUNT + DIMM_COUNT;

  localparam logic [63:0] TIME_MAX64 = {64{1'b1}} >> (64 - TIME_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE, S_REM, S_ALIGN, S_RD, S_UPD, S_LAT, S_SAT, S_SUM, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    LVL_CHANNEL, LVL_DEVICE, LVL_DIMM, LVL_BANK
  } level_t;

  state_t state;
  level_t lvl;

  // configuration registers
  logic [CMD_MULT_W-1:0]  cmd_clock_mult;
  logic [BANK_MULT_W-1:0] bank_clock_mult;
  logic [TRC_W-1:0]       row_cycle_time;
  logic [TRAS_W-1:0]      row_active_time;
  logic [XFER_W-1:0]      transfer_time;
  logic [SHIFT_W-1:0]     line_size_log;

  // per-request working registers
  logic [TIME_WIDTH-1:0]  t0;
  logic [TIME_WIDTH-1:0]  t;
  logic [TIME_WIDTH-1:0]  lat;
  logic [LW-1:0]          line_idx;
  logic [LAT_W-1:0]       access_latency;
  logic [TOTAL_W-1:0]     latency_total;

  logic                   req_fire;
  logic [63:0]            ts64;
  logic [TIME_WIDTH-1:0]  t0_in;
  logic [ADDR_W-1:0]      line_full;

  logic                   clear_done;
  logic                   rem_done;
  logic [7:0]             rem_val;

  logic [TIME_WIDTH-1:0]  alu_a;
  logic [TIME_WIDTH-1:0]  alu_b;
  logic [TIME_WIDTH-1:0]  alu_y;
  logic [TIME_WIDTH-1:0]  rd_data;
  logic [AW-1:0]          lvl_addr;
  logic [TIME_WIDTH-1:0]  spacing;
  logic [7:0]             align_delta;
  logic [TIME_WIDTH:0]    lat_sum;

  assign req.ready = (state == S_IDLE) && clear_done;
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid          = (state == S_OUT);
  assign rsp.access_latency = access_latency;
  assign rsp.latency_total  = latency_total;

  // arrival time clamps at the time limit when the time word is narrow
  always_comb begin
    ts64      = 64'(req.timestamp);
    t0_in     = (ts64 > TIME_MAX64) ? {TIME_WIDTH{1'b1}} : ts64[TIME_WIDTH-1:0];
    line_full = req.phys_address >> line_size_log;
  end

  // table address and spacing of the level in hand
  always_comb begin
    unique case (lvl)
      LVL_CHANNEL: begin
        lvl_addr = AW'(line_idx & LW'(CHANNELS - 1));
        spacing  = TIME_WIDTH'(cmd_clock_mult);
      end
      LVL_DEVICE: begin
        lvl_addr = AW'(line_idx & LW'(DEV_COUNT - 1)) + AW'(BASE_DEV);
        spacing  = TIME_WIDTH'(transfer_time);
      end
      LVL_DIMM: begin
        lvl_addr = AW'(line_idx & LW'(DIMM_COUNT - 1)) + AW'(BASE_DIMM);
        spacing  = TIME_WIDTH'(bank_clock_mult);
      end
      LVL_BANK: begin
        lvl_addr = AW'(line_idx & LW'(BANK_COUNT - 1)) + AW'(BASE_BANK);
        spacing  = TIME_WIDTH'(row_cycle_time);
      end
      default: begin
        lvl_addr = '0;
        spacing  = '0;
      end
    endcase
  end

  // round-up distance; a zero multiplier or an aligned time means no move
  assign align_delta = ((cmd_clock_mult != '0) && (rem_val != '0)) ?
                       (cmd_clock_mult - rem_val) : 8'd0;

  // shared adder: alignment step, then each level against its last time
  always_comb begin
    if (state == S_ALIGN) begin
      alu_a = t;
      alu_b = TIME_WIDTH'(align_delta);
    end else begin
      alu_a = rd_data;
      alu_b = spacing;
    end
  end

  drct_alu #(.TIME_WIDTH(TIME_WIDTH)) u_alu (
    .a          (alu_a),
    .b          (alu_b),
    .floor_time (t),
    .y          (alu_y)
  );

  drct_rem #(.TIME_WIDTH(TIME_WIDTH)) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (req_fire),
    .value     (t0_in),
    .divisor   (cmd_clock_mult),
    .done      (rem_done),
    .remainder (rem_val)
  );

  drct_tables #(.DEPTH(DEPTH), .DATA_W(TIME_WIDTH)) u_tables (
    .clk        (clk),
    .rst        (rst),
    .clear_done (clear_done),
    .rd_en      (state == S_RD),
    .rd_addr    (lvl_addr),
    .rd_data    (rd_data),
    .wr_en      (state == S_UPD),
    .wr_addr    (lvl_addr),
    .wr_data    (alu_y)
  );

  assign lat_sum = (TIME_WIDTH + 1)'(lat) + (TIME_WIDTH + 1)'(row_active_time);

  // configuration writes, taken at any time
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_clock_mult  <= CMD_MULT_W'(1);
      bank_clock_mult <= BANK_MULT_W'(1);
      row_cycle_time  <= TRC_W'(1);
      row_active_time <= TRAS_W'(1);
      transfer_time   <= XFER_W'(1);
      line_size_log   <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CMD_CLOCK_MULT:  cmd_clock_mult  <= cfg.data[CMD_MULT_W-1:0];
        REG_BANK_CLOCK_MULT: bank_clock_mult <= cfg.data[BANK_MULT_W-1:0];
        REG_ROW_CYCLE_TIME:  row_cycle_time  <= cfg.data[TRC_W-1:0];
        REG_ROW_ACTIVE_TIME: row_active_time <= cfg.data[TRAS_W-1:0];
        REG_TRANSFER_TIME:   transfer_time   <= cfg.data[XFER_W-1:0];
        REG_LINE_SIZE_LOG:   line_size_log   <= cfg.data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      lvl           <= LVL_CHANNEL;
      latency_total <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            t0       <= t0_in;
            t        <= t0_in;
            line_idx <= line_full[LW-1:0];
            state    <= S_REM;
          end
        end
        S_REM: begin
          if (rem_done) begin
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          t     <= alu_y;
          lvl   <= LVL_CHANNEL;
          state <= S_RD;
        end
        S_RD: begin
          // last time arrives from memory next cycle
          state <= S_UPD;
        end
        S_UPD: begin
          t <= alu_y;
          if (lvl == LVL_BANK) begin
            state <= S_LAT;
          end else begin
            lvl   <= level_t'(lvl + 2'd1);
            state <= S_RD;
          end
        end
        S_LAT: begin
          lat   <= t - t0;
          state <= S_SAT;
        end
        S_SAT: begin
          // clamp latency plus tras to 32 bits
          if (lat_sum[TIME_WIDTH:LAT_W] != '0) begin
            access_latency <= {LAT_W{1'b1}};
          end else begin
            access_latency <= lat_sum[LAT_W-1:0];
          end
          state <= S_SUM;
        end
        S_SUM: begin
          latency_total <= latency_total + TOTAL_W'(access_latency);
          state         <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
